// ----- rtl/core/brm_pkg.sv -----
// shared types, constants and helpers of the blurred rectangle mask generator
`timescale 1ns / 1ps

package brm_pkg;

  // field widths
  localparam int INV_W   = 20;
  localparam int PSZ_W   = 9;
  localparam int DIM_W   = 12;
  localparam int COORD_W = 13;
  localparam int ALPHA_W = 8;
  localparam int ARG_W   = 20;
  localparam int G_W     = 17;
  localparam int IDX_W   = 3;

  // longest profile the hardware evaluates
  localparam logic [PSZ_W-1:0] MAX_PROFILE = 9'd256;

  // pipeline depths: axis path from coordinate to axis value, whole block
  localparam int AXIS_LAT = 10;
  localparam int PIPE_LAT = AXIS_LAT + 2;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_INV_TWO_SIGMA = 3'd0,
    REG_PROFILE_LEN   = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_BLUR_STYLE    = 3'd4
  } cfg_reg_t;

  // blur styles
  typedef enum logic [1:0] {
    STYLE_NORMAL = 2'd0,
    STYLE_SOLID  = 2'd1,
    STYLE_OUTER  = 2'd2,
    STYLE_INNER  = 2'd3
  } blur_style_t;

  // per-axis setup handed to an axis unit
  typedef struct packed {
    logic [PSZ_W-1:0] psize;
    logic [DIM_W-1:0] rect;
    logic [INV_W-1:0] inv;
  } axis_cfg_t;

  // override of the blurred value
  typedef struct packed {
    logic               en;
    logic [ALPHA_W-1:0] val;
  } force_t;

  // exact Q17 value to Q4.16, rounded down and saturated
  function automatic logic signed [ARG_W-1:0] to_arg(input logic signed [37:0] v);
    logic signed [37:0] h;
    h = v >>> 1;
    if (h > 38'sd524287) begin
      return 20'sd524287;
    end else if (h < -38'sd524288) begin
      return -20'sd524288;
    end
    return h[ARG_W-1:0];
  endfunction

endpackage

// ----- rtl/core/brm_if.sv -----
// channel interfaces: pixel coordinates in, alpha out, register writes
`timescale 1ns / 1ps

interface brm_pix_if import brm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface brm_alpha_if import brm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] mask_alpha;
  modport source (output valid, output mask_alpha, input ready);
  modport sink (input valid, input mask_alpha, output ready);
endinterface

interface brm_cfg_if import brm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [INV_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/brm_integral.sv -----
// pipelined piecewise-cubic edge integral, Q4.16 argument to unsigned Q1.16 result
`timescale 1ns / 1ps

module brm_integral import brm_pkg::*; (
  input  logic                    clk,
  input  logic                    ce,
  input  logic signed [ARG_W-1:0] x,
  output logic        [G_W-1:0]   g
);

  localparam logic signed [ARG_W-1:0] X_EDGE = 20'sd98304;
  localparam logic signed [ARG_W-1:0] X_KNEE = 20'sd32768;
  localparam logic signed [55:0] C_UP  = 56'sd27 <<< 45;
  localparam logic signed [55:0] C_MID = 56'sd3 <<< 48;
  localparam logic signed [55:0] C_LO  = 56'sd21 <<< 45;
  localparam logic [19:0] RECIP6 = 20'd699051;
  localparam logic [G_W-1:0] G_ONE = 17'd65536;

  typedef struct packed {
    logic zero;
    logic full;
    logic upper;
    logic middle;
  } piece_t;

  piece_t             pc1, pc2, pc3;
  logic signed [17:0] xc_next, xc1, xc2;
  logic signed [35:0] x2_1, x2_2;
  logic signed [53:0] x3_2;
  logic signed [55:0] num_next, num3;
  logic               zero4, full4;
  logic        [18:0] n_next;
  logic        [38:0] prod4;
  logic        [G_W-1:0] q_raw;

  // stage 1: piece select, clamp, square
  always_comb begin
    if (x > X_EDGE) begin
      xc_next = 18'sd98304;
    end else if (x < -X_EDGE) begin
      xc_next = -18'sd98304;
    end else begin
      xc_next = x[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pc1.zero   <= x > X_EDGE;
      pc1.full   <= x < -X_EDGE;
      pc1.upper  <= x > X_KNEE;
      pc1.middle <= x > -X_KNEE;
      xc1        <= xc_next;
      x2_1       <= xc_next * xc_next;
    end
  end

  // stage 2: cube
  always_ff @(posedge clk) begin
    if (ce) begin
      pc2  <= pc1;
      xc2  <= xc1;
      x2_2 <= x2_1;
      x3_2 <= x2_1 * xc1;
    end
  end

  // stage 3: polynomial of the selected piece, scaled by 6 * 2^48
  always_comb begin
    if (pc2.upper) begin
      num_next = C_UP - 56'(x3_2) + ((56'(x2_2) * 56'sd9) <<< 15)
                 - ((56'(xc2) * 56'sd27) <<< 30);
    end else if (pc2.middle) begin
      num_next = C_MID - ((56'(xc2) * 56'sd9) <<< 31) + (56'(x3_2) <<< 1);
    end else begin
      num_next = C_LO - 56'(x3_2) - ((56'(x2_2) * 56'sd9) <<< 15)
                 - ((56'(xc2) * 56'sd27) <<< 30);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pc3  <= pc2;
      num3 <= num_next;
    end
  end

  // stage 4: divide by 6 * 2^32 through a reciprocal
  always_comb begin
    if (num3[55:51] != 5'd0) begin
      n_next = '1;
    end else begin
      n_next = num3[50:32];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      zero4 <= pc3.zero || num3[55];
      full4 <= pc3.full;
      prod4 <= 39'(n_next) * 39'(RECIP6);
    end
  end

  // stage 5: saturate and apply the constant tails
  assign q_raw = prod4[38:22];

  always_ff @(posedge clk) begin
    if (ce) begin
      if (full4) begin
        g <= G_ONE;
      end else if (zero4) begin
        g <= '0;
      end else if (q_raw > G_ONE) begin
        g <= G_ONE;
      end else begin
        g <= q_raw;
      end
    end
  end

endmodule

// ----- rtl/core/brm_axis.sv -----
// one axis of the blur: profile entry or difference of the edge integrals at both rectangle edges
`timescale 1ns / 1ps

module brm_axis import brm_pkg::*; (
  input  logic               clk,
  input  logic               ce,
  input  axis_cfg_t          cfg,
  input  logic [COORD_W-1:0] c,
  output logic [ALPHA_W-1:0] value
);

  typedef struct packed {
    logic wide;
    logic k0;
  } side_t;

  localparam int SIDE_LEN = 8;

  logic [COORD_W-1:0]     c0;
  logic [7:0]             pad;
  logic [COORD_W-1:0]     len;
  logic signed [13:0]     s, ctr;
  logic                   wide;
  logic [13:0]            c2;
  logic signed [14:0]     diff, adiff;
  logic signed [15:0]     dx;
  logic [14:0]            k_raw;
  logic [7:0]             k_max, kc;
  logic signed [10:0]     m_next;
  side_t                  side_q [SIDE_LEN];
  logic signed [10:0]     m1;
  logic [13:0]            c2_1;
  logic signed [14:0]     s2_1;
  logic signed [31:0]     pw2;
  logic [33:0]            pa2;
  logic signed [35:0]     ps2;
  logic signed [37:0]     a17, b17;
  logic signed [ARG_W-1:0] xa3, xb3;
  logic [G_W-1:0]         ga, gb;
  logic signed [G_W:0]    d;
  logic [24:0]            scaled;
  side_t                  side_o;

  // input register
  always_ff @(posedge clk) begin
    if (ce) begin
      c0 <= c;
    end
  end

  // stage 1: profile geometry and index
  assign pad   = cfg.psize[8:1];
  assign len   = COORD_W'(cfg.rect) + COORD_W'({pad, 1'b0});
  assign s     = $signed({2'b00, cfg.rect}) - $signed({13'd0, cfg.psize[0]});
  assign ctr   = $signed({5'd0, pad, 1'b0}) - 14'sd1;
  assign wide  = s >= $signed({5'd0, cfg.psize});
  assign c2    = {c0, 1'b1};
  assign diff  = $signed({1'b0, c2}) - $signed({2'b00, len});
  assign adiff = diff[14] ? -diff : diff;
  assign dx    = 16'(adiff) - 16'(s - ctr);
  assign k_raw = dx[15] ? 15'd0 : dx[15:1];
  assign k_max = 8'(cfg.psize - 9'd1);
  assign kc    = (k_raw > 15'(k_max)) ? k_max : k_raw[7:0];
  assign m_next = (($signed({3'b000, pad}) - $signed({3'b000, kc})) <<< 1) - 11'sd1;

  always_ff @(posedge clk) begin
    if (ce) begin
      m1   <= m_next;
      c2_1 <= c2;
      s2_1 <= 15'(s) <<< 1;
    end
  end

  // stage 2: scale by the reciprocal of twice sigma
  always_ff @(posedge clk) begin
    if (ce) begin
      pw2 <= 32'(m1 * $signed({1'b0, cfg.inv}));
      pa2 <= 34'(c2_1) * 34'(cfg.inv);
      ps2 <= 36'(s2_1 * $signed({1'b0, cfg.inv}));
    end
  end

  // stage 3: integral arguments
  assign a17 = 38'sd196608 - $signed({4'd0, pa2});
  assign b17 = a17 + 38'(ps2);

  always_ff @(posedge clk) begin
    if (ce) begin
      xa3 <= to_arg(side_q[1].wide ? 38'(pw2) : a17);
      xb3 <= to_arg(b17);
    end
  end

  // side data follows the items through the integral units
  always_ff @(posedge clk) begin
    if (ce) begin
      side_q[0].wide <= wide;
      side_q[0].k0   <= kc == 8'd0;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  brm_integral u_int_a (.clk(clk), .ce(ce), .x(xa3), .g(ga));
  brm_integral u_int_b (.clk(clk), .ce(ce), .x(xb3), .g(gb));

  // output stage: profile entry or clipped difference, times 255
  assign side_o = side_q[SIDE_LEN-1];
  assign d      = $signed({1'b0, ga}) - $signed({1'b0, gb});

  always_comb begin
    if (side_o.wide) begin
      scaled = 25'(ga) * 25'd255;
    end else if (d[G_W]) begin
      scaled = '0;
    end else begin
      scaled = 25'(d[G_W-1:0]) * 25'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (!side_o.wide) begin
        value <= scaled[23:16];
      end else if (side_o.k0) begin
        value <= 8'd255;
      end else begin
        value <= 8'd255 - scaled[23:16];
      end
    end
  end

endmodule

// ----- rtl/core/blurred_rect_mask_generator.sv -----
// top level: blurred rectangle mask generator
//
//   channel    dir  payload                      handshake
//   cfg        in   index[2:0], data[19:0]       valid/ready, always ready
//   pix_in     in   pixel_x[12:0], pixel_y[12:0] valid/ready
//   alpha_out  out  mask_alpha[7:0]              valid/ready
//
// one pixel per cycle while alpha_out is not stalled; a transferred pixel's
// valid bit runs through the whole vld shift register to alpha_out.valid.
// part of the depth is the edge integral: square, cube, polynomial, reciprocal
// divide and saturation each take one register stage.
// rst is synchronous; it resets the configuration registers and clears all valid bits.
// the whole pipeline advances whenever the output stage is empty or taken, so
// a stall on alpha_out holds every stage and pix_in.ready drops with it.
`timescale 1ns / 1ps

module blurred_rect_mask_generator import brm_pkg::*; (
  input logic         clk,
  input logic         rst,
  brm_cfg_if.sink     cfg,
  brm_pix_if.sink     pix_in,
  brm_alpha_if.source alpha_out
);

  logic [INV_W-1:0]   inv_two_sigma;
  logic [PSZ_W-1:0]   profile_len;
  logic [DIM_W-1:0]   rect_width;
  logic [DIM_W-1:0]   rect_height;
  blur_style_t        blur_style;

  logic [PSZ_W-1:0]   psize;
  logic [7:0]         pad;
  logic [COORD_W-1:0] dw, dh, lo_w, lo_h, hi_w, hi_h;
  logic               ce, accept, inner, outside, interior;
  force_t             force_next;
  force_t             force_q [AXIS_LAT];
  force_t             force_m;
  logic [COORD_W-1:0] cx, cy;
  axis_cfg_t          cfg_x, cfg_y;
  logic [ALPHA_W-1:0] h, v;
  logic [15:0]        t_m;
  logic [16:0]        t_sum;
  logic [PIPE_LAT-1:0] vld;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_two_sigma <= 20'd65536;
      profile_len   <= 9'd6;
      rect_width    <= '0;
      rect_height   <= '0;
      blur_style    <= STYLE_NORMAL;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_INV_TWO_SIGMA: inv_two_sigma <= cfg.data;
        REG_PROFILE_LEN:   profile_len   <= cfg.data[PSZ_W-1:0];
        REG_RECT_WIDTH:    rect_width    <= cfg.data[DIM_W-1:0];
        REG_RECT_HEIGHT:   rect_height   <= cfg.data[DIM_W-1:0];
        REG_BLUR_STYLE:    blur_style    <= blur_style_t'(cfg.data[1:0]);
        default: ;
      endcase
    end
  end

  // effective profile size and padded extents
  always_comb begin
    if (profile_len == '0) begin
      psize = 9'd1;
    end else if (profile_len > MAX_PROFILE) begin
      psize = MAX_PROFILE;
    end else begin
      psize = profile_len;
    end
  end

  assign pad  = psize[8:1];
  assign dw   = COORD_W'(rect_width) + COORD_W'({pad, 1'b0});
  assign dh   = COORD_W'(rect_height) + COORD_W'({pad, 1'b0});
  assign lo_w = COORD_W'(pad);
  assign lo_h = COORD_W'(pad);
  assign hi_w = COORD_W'(pad) + COORD_W'(rect_width);
  assign hi_h = COORD_W'(pad) + COORD_W'(rect_height);

  assign cfg_x = '{psize: psize, rect: rect_width, inv: inv_two_sigma};
  assign cfg_y = '{psize: psize, rect: rect_height, inv: inv_two_sigma};

  // handshake and pipeline advance
  assign ce              = !vld[PIPE_LAT-1] || alpha_out.ready;
  assign pix_in.ready    = ce;
  assign accept          = pix_in.valid && ce;
  assign alpha_out.valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  // style decisions on the incoming pixel
  assign inner    = blur_style == STYLE_INNER;
  assign interior = pix_in.pixel_x >= lo_w && pix_in.pixel_x < hi_w &&
                    pix_in.pixel_y >= lo_h && pix_in.pixel_y < hi_h;

  always_comb begin
    if (inner) begin
      outside = pix_in.pixel_x >= COORD_W'(rect_width) ||
                pix_in.pixel_y >= COORD_W'(rect_height);
    end else begin
      outside = pix_in.pixel_x >= dw || pix_in.pixel_y >= dh;
    end
  end

  always_comb begin
    force_next = '{en: 1'b0, val: 8'd0};
    if (outside) begin
      force_next = '{en: 1'b1, val: 8'd0};
    end else if (interior && blur_style == STYLE_SOLID) begin
      force_next = '{en: 1'b1, val: 8'd255};
    end else if (interior && blur_style == STYLE_OUTER) begin
      force_next = '{en: 1'b1, val: 8'd0};
    end
  end

  assign cx = inner ? pix_in.pixel_x + COORD_W'(pad) : pix_in.pixel_x;
  assign cy = inner ? pix_in.pixel_y + COORD_W'(pad) : pix_in.pixel_y;

  // override follows the axis units
  always_ff @(posedge clk) begin
    if (ce) begin
      force_q[0] <= force_next;
      for (int i = 1; i < AXIS_LAT; i++) begin
        force_q[i] <= force_q[i-1];
      end
    end
  end

  brm_axis u_axis_x (.clk(clk), .ce(ce), .cfg(cfg_x), .c(cx), .value(h));
  brm_axis u_axis_y (.clk(clk), .ce(ce), .cfg(cfg_y), .c(cy), .value(v));

  // merge: rounded h * v / 255
  always_ff @(posedge clk) begin
    if (ce) begin
      t_m     <= 16'(h) * 16'(v) + 16'd128;
      force_m <= force_q[AXIS_LAT-1];
    end
  end

  assign t_sum = 17'(t_m) + 17'(t_m[15:8]);

  always_ff @(posedge clk) begin
    if (ce) begin
      alpha_out.mask_alpha <= force_m.en ? force_m.val : t_sum[15:8];
    end
  end

  // checks
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> vld[0])
    else $error("accepted pixel did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> alpha_out.valid && !alpha_out.ready)
    else $error("input held off without a blocked result");

endmodule
